// File: design/cbis_pkg.sv
// Shared types and constants for the CBOR item skip checker.
`default_nettype none

package cbis_pkg;

   localparam int LENGTH_BITS_DEFAULT = 32;

   localparam logic [7:0] SIMPLE_FALSE = 8'hF4;
   localparam logic [7:0] SIMPLE_TRUE  = 8'hF5;
   localparam logic [7:0] SIMPLE_NULL  = 8'hF6;
   localparam logic [4:0] AI_MASK      = 5'h1F;

   // Additional-information codes: below DIRECT the value is inline,
   // up to SIZED_LAST it names the size of a following argument.
   localparam logic [4:0] AI_DIRECT_LIMIT = 5'd24;
   localparam logic [4:0] AI_SIZED_LAST   = 5'd27;

   localparam logic [2:0] MAJOR_BYTES  = 3'd2;
   localparam logic [2:0] MAJOR_TEXT   = 3'd3;
   localparam logic [2:0] MAJOR_ARRAY  = 3'd4;
   localparam logic [2:0] MAJOR_MAP    = 3'd5;
   localparam logic [2:0] MAJOR_TAG    = 3'd6;
   localparam logic [2:0] MAJOR_SIMPLE = 3'd7;

   typedef enum logic [1:0] {
      STATUS_IDLE  = 2'd0,
      STATUS_BUSY  = 2'd1,
      STATUS_DONE  = 2'd2,
      STATUS_ERROR = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PH_INIT    = 2'd0,
      PH_ARG     = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        start_req;
      logic [31:0] bytes_remaining;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [2:0]  head_major;
      logic [63:0] head_argument;
   } rsp_type;

endpackage

`default_nettype wire

// File: design/cbis_core.sv
// Per-byte parse state and single-pass step logic for the item skip checker.
`default_nettype none

module cbis_core #(
   parameter int LENGTH_BITS = cbis_pkg::LENGTH_BITS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step_en,
   input  wire cbis_pkg::req_type item,
   output cbis_pkg::rsp_type     result
);

   localparam int OwedBits = LENGTH_BITS + 2;
   localparam int SumBits  = LENGTH_BITS + 3;

   logic                     active_ff,  active_in;
   logic                     error_ff,   error_in;
   cbis_pkg::phase_type      phase_ff,   phase_in;
   logic [2:0]               held_ff,    held_in;
   logic [3:0]               abl_ff,     abl_in;
   logic [63:0]              acc_ff,     acc_in;
   logic [LENGTH_BITS-1:0]   pay_ff,     pay_in;
   logic [OwedBits-1:0]      owed_ff,    owed_in;
   logic [2:0]               lmajor_ff,  lmajor_in;
   logic [63:0]              larg_ff,    larg_in;

   logic [63:0]              rem_wide;
   logic [LENGTH_BITS-1:0]   rem;

   assign rem_wide = {32'd0, item.bytes_remaining};
   assign rem      = rem_wide[LENGTH_BITS-1:0];

   always_comb begin
      logic [7:0]             b;
      logic [2:0]             major;
      logic [4:0]             ai;
      logic [3:0]             arg_len;
      logic                   head_done;
      logic                   fail;
      logic [63:0]            arg;
      logic [LENGTH_BITS:0]   add;
      logic [SumBits-1:0]     sum;
      cbis_pkg::status_type   status;

      active_in = active_ff;
      error_in  = error_ff;
      phase_in  = phase_ff;
      held_in   = held_ff;
      abl_in    = abl_ff;
      acc_in    = acc_ff;
      pay_in    = pay_ff;
      owed_in   = owed_ff;
      lmajor_in = lmajor_ff;
      larg_in   = larg_ff;
      b         = item.data_byte;
      major     = b[7:5];
      ai        = b[4:0] & cbis_pkg::AI_MASK;
      arg_len   = 4'd1 << ai[1:0];
      head_done = 1'b0;
      fail      = 1'b0;
      arg       = '0;
      add       = '0;
      sum       = '0;
      status    = cbis_pkg::STATUS_IDLE;

      if (item.start_req) begin
         active_in = 1'b1;
         error_in  = 1'b0;
         phase_in  = cbis_pkg::PH_INIT;
         owed_in   = OwedBits'(1);
         abl_in    = '0;
         pay_in    = '0;
      end

      if (!active_in) begin
         status = error_in ? cbis_pkg::STATUS_ERROR : cbis_pkg::STATUS_IDLE;
      end else begin
         unique case (phase_in)
            cbis_pkg::PH_ARG: begin
               acc_in = {acc_in[55:0], b};
               abl_in = abl_in - 4'd1;
               if (abl_in == 4'd0) begin
                  phase_in  = cbis_pkg::PH_INIT;
                  head_done = 1'b1;
               end
            end
            cbis_pkg::PH_PAYLOAD: begin
               pay_in = pay_in - LENGTH_BITS'(1);
               if (pay_in == '0) begin
                  phase_in = cbis_pkg::PH_INIT;
               end
            end
            default: begin
               // initial byte of a head; the unused phase code lands here too
               phase_in = cbis_pkg::PH_INIT;
               if (major == cbis_pkg::MAJOR_SIMPLE) begin
                  if (b == cbis_pkg::SIMPLE_FALSE || b == cbis_pkg::SIMPLE_TRUE ||
                      b == cbis_pkg::SIMPLE_NULL) begin
                     held_in   = cbis_pkg::MAJOR_SIMPLE;
                     acc_in    = 64'(ai);
                     head_done = 1'b1;
                  end else begin
                     fail = 1'b1;
                  end
               end else if (major == cbis_pkg::MAJOR_TAG) begin
                  fail = 1'b1;
               end else if (ai < cbis_pkg::AI_DIRECT_LIMIT) begin
                  held_in   = major;
                  acc_in    = 64'(ai);
                  head_done = 1'b1;
               end else if (ai <= cbis_pkg::AI_SIZED_LAST) begin
                  if (rem < LENGTH_BITS'(arg_len)) begin
                     fail = 1'b1;
                  end else begin
                     held_in  = major;
                     acc_in   = '0;
                     abl_in   = arg_len;
                     phase_in = cbis_pkg::PH_ARG;
                  end
               end else begin
                  fail = 1'b1;
               end
            end
         endcase

         if (head_done) begin
            arg       = acc_in;
            lmajor_in = held_in;
            larg_in   = arg;
            if (owed_in != '0) begin
               owed_in = owed_in - OwedBits'(1);
            end
            if (held_in == cbis_pkg::MAJOR_BYTES || held_in == cbis_pkg::MAJOR_TEXT) begin
               if (arg > 64'(rem)) begin
                  fail = 1'b1;
               end else if (arg != '0) begin
                  pay_in   = arg[LENGTH_BITS-1:0];
                  phase_in = cbis_pkg::PH_PAYLOAD;
               end
            end else if (held_in == cbis_pkg::MAJOR_ARRAY ||
                         held_in == cbis_pkg::MAJOR_MAP) begin
               if (arg > 64'(rem)) begin
                  fail = 1'b1;
               end else begin
                  // count fits the length width here; a map owes two per entry
                  add = (held_in == cbis_pkg::MAJOR_MAP) ?
                        {arg[LENGTH_BITS-1:0], 1'b0} : {1'b0, arg[LENGTH_BITS-1:0]};
                  sum = {1'b0, owed_in} + SumBits'(add);
                  if (sum[SumBits-1]) begin
                     fail = 1'b1;
                  end else begin
                     owed_in = sum[OwedBits-1:0];
                  end
               end
            end
         end

         if (!fail) begin
            if (owed_in == '0 && phase_in == cbis_pkg::PH_INIT) begin
               status    = cbis_pkg::STATUS_DONE;
               active_in = 1'b0;
            end else if (rem == '0) begin
               fail = 1'b1;
            end else begin
               status = cbis_pkg::STATUS_BUSY;
            end
         end

         if (fail) begin
            error_in  = 1'b1;
            active_in = 1'b0;
            phase_in  = cbis_pkg::PH_INIT;
            abl_in    = '0;
            pay_in    = '0;
            status    = cbis_pkg::STATUS_ERROR;
         end
      end

      result.status        = status;
      result.head_major    = lmajor_in;
      result.head_argument = larg_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         error_ff  <= 1'b0;
         phase_ff  <= cbis_pkg::PH_INIT;
         held_ff   <= '0;
         abl_ff    <= '0;
         acc_ff    <= '0;
         pay_ff    <= '0;
         owed_ff   <= '0;
         lmajor_ff <= '0;
         larg_ff   <= '0;
      end else if (step_en) begin
         active_ff <= active_in;
         error_ff  <= error_in;
         phase_ff  <= phase_in;
         held_ff   <= held_in;
         abl_ff    <= abl_in;
         acc_ff    <= acc_in;
         pay_ff    <= pay_in;
         owed_ff   <= owed_in;
         lmajor_ff <= lmajor_in;
         larg_ff   <= larg_in;
      end
   end

endmodule

`default_nettype wire

// File: design/cbor_item_skip_checker.sv
// Top level of the CBOR item skip checker: handshake registers around the step core.
// One encoded byte enters per item and one status item leaves for each, in order.
// The block sustains one byte per cycle while the result side is ready. A byte accepted
// into the request register is stepped through cbis_core when it advances, and its status item
// enters the result register in that step, from which it can then leave. The step is a
// single pass in cbis_core, whose parse state updates in the same cycle the byte moves into
// the result register. Backpressure on the result side stalls the input side only once both
// registers hold an item.
`default_nettype none

module cbor_item_skip_checker #(
   parameter int LENGTH_BITS = cbis_pkg::LENGTH_BITS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire cbis_pkg::req_type req_item,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output cbis_pkg::rsp_type      rsp_item
);

   logic              req_valid_ff;
   cbis_pkg::req_type req_ff;
   logic              rsp_valid_ff;
   cbis_pkg::rsp_type rsp_ff;
   cbis_pkg::rsp_type step_result;
   logic              advance;

   // move the held byte through the step when the result register frees up
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   cbis_core #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (req_ff),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_item;
      end
      if (advance) begin
         rsp_ff <= step_result;
      end
   end

endmodule

`default_nettype wire

// File: tb/sv/cbor_item_skip_checker_tb.sv
// Self-checking testbench for the CBOR item skip checker: directed table plus random streams.
`timescale 1ns / 1ps

module cbor_item_skip_checker_tb;

   localparam logic [2:0]  MAJOR_UNSIGNED = 3'd0;
   localparam logic [2:0]  MAJOR_NEGATIVE = 3'd1;
   localparam logic [63:0] OWED_MAX       =
      (64'd1 << (cbis_pkg::LENGTH_BITS_DEFAULT + 2)) - 64'd1;
   localparam int          RANDOM_BYTES   = 420;
   localparam int          STALL_LIMIT    = 1000;
   localparam int          DRAIN_CYCLES   = 6;

   typedef enum int {
      GEN_NUMBER,
      GEN_SIMPLE,
      GEN_STRING,
      GEN_ARRAY,
      GEN_MAP
   } gen_kind_type;

   typedef struct packed {
      cbis_pkg::req_type item;
      bit                typed;
      cbis_pkg::rsp_type want;
   } dir_row_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   cbis_pkg::req_type req_item;
   logic              rsp_valid;
   logic              rsp_ready;
   cbis_pkg::rsp_type rsp_item;

   // typed expectation that rides along with the item on the request side
   bit                row_typed;
   cbis_pkg::rsp_type row_rsp;

   bit      steady_req;
   bit      steady_ready;
   int      stall_left;
   int      quiet_cycles;
   int      fault_count;
   int      done_seen;
   int      error_seen;
   int      directed_sent;
   int      random_sent;

   cbis_pkg::rsp_type byte_result_q[$];
   logic [7:0]        enc_bytes[$];
   dir_row_type       dir_tab[$];

   // parser state as the block should hold it
   logic                trk_active;
   logic                trk_error;
   cbis_pkg::phase_type trk_phase;
   logic [2:0]          trk_held_major;
   logic [3:0]          trk_arg_left;
   logic [63:0]         trk_acc;
   logic [31:0]         trk_payload;
   logic [33:0]         trk_owed;
   logic [2:0]          trk_last_major;
   logic [63:0]         trk_last_arg;

   cbor_item_skip_checker dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic cbis_pkg::rsp_type skip_step(input cbis_pkg::req_type it);
      logic [7:0]           b;
      logic [63:0]          rem;
      logic [2:0]           mj;
      logic [4:0]           ai;
      logic [3:0]           width;
      logic [63:0]          arg;
      logic [63:0]          add;
      logic                 head_done;
      logic                 fail;
      cbis_pkg::status_type st;
      cbis_pkg::rsp_type    r;
      b = it.data_byte;
      rem = 64'(it.bytes_remaining);
      head_done = 1'b0;
      fail = 1'b0;
      st = cbis_pkg::STATUS_IDLE;
      if (it.start_req) begin
         trk_active = 1'b1;
         trk_error = 1'b0;
         trk_phase = cbis_pkg::PH_INIT;
         trk_owed = 34'd1;
         trk_arg_left = 4'd0;
         trk_payload = 32'd0;
      end
      if (!trk_active) begin
         st = trk_error ? cbis_pkg::STATUS_ERROR : cbis_pkg::STATUS_IDLE;
      end else begin
         if (trk_phase == cbis_pkg::PH_ARG) begin
            trk_acc = {trk_acc[55:0], b};
            trk_arg_left = trk_arg_left - 4'd1;
            if (trk_arg_left == 4'd0) begin
               trk_phase = cbis_pkg::PH_INIT;
               head_done = 1'b1;
            end
         end else if (trk_phase == cbis_pkg::PH_PAYLOAD) begin
            trk_payload = trk_payload - 32'd1;
            if (trk_payload == 32'd0) trk_phase = cbis_pkg::PH_INIT;
         end else begin
            mj = b[7:5];
            ai = b[4:0];
            trk_phase = cbis_pkg::PH_INIT;
            if (mj == cbis_pkg::MAJOR_SIMPLE) begin
               if (b == cbis_pkg::SIMPLE_FALSE || b == cbis_pkg::SIMPLE_TRUE ||
                   b == cbis_pkg::SIMPLE_NULL) begin
                  trk_held_major = cbis_pkg::MAJOR_SIMPLE;
                  trk_acc = 64'(ai);
                  head_done = 1'b1;
               end else begin
                  fail = 1'b1;
               end
            end else if (mj == cbis_pkg::MAJOR_TAG) begin
               fail = 1'b1;
            end else if (ai < cbis_pkg::AI_DIRECT_LIMIT) begin
               trk_held_major = mj;
               trk_acc = 64'(ai);
               head_done = 1'b1;
            end else if (ai <= cbis_pkg::AI_SIZED_LAST) begin
               width = 4'd1 << (ai - cbis_pkg::AI_DIRECT_LIMIT);
               if (rem < 64'(width)) begin
                  fail = 1'b1;
               end else begin
                  trk_held_major = mj;
                  trk_acc = 64'd0;
                  trk_arg_left = width;
                  trk_phase = cbis_pkg::PH_ARG;
               end
            end else begin
               fail = 1'b1;
            end
         end

         if (head_done && !fail) begin
            arg = trk_acc;
            trk_last_major = trk_held_major;
            trk_last_arg = arg;
            if (trk_owed != 34'd0) trk_owed = trk_owed - 34'd1;
            if (trk_held_major == cbis_pkg::MAJOR_BYTES ||
                trk_held_major == cbis_pkg::MAJOR_TEXT) begin
               if (arg > rem) begin
                  fail = 1'b1;
               end else if (arg != 64'd0) begin
                  trk_payload = arg[31:0];
                  trk_phase = cbis_pkg::PH_PAYLOAD;
               end
            end else if (trk_held_major == cbis_pkg::MAJOR_ARRAY ||
                         trk_held_major == cbis_pkg::MAJOR_MAP) begin
               if (arg > rem) begin
                  fail = 1'b1;
               end else begin
                  add = (trk_held_major == cbis_pkg::MAJOR_MAP) ? arg << 1 : arg;
                  if (add > OWED_MAX - 64'(trk_owed)) fail = 1'b1;
                  else trk_owed = trk_owed + add[33:0];
               end
            end
         end

         if (!fail) begin
            if (trk_owed == 34'd0 && trk_phase == cbis_pkg::PH_INIT) begin
               st = cbis_pkg::STATUS_DONE;
               trk_active = 1'b0;
            end else if (rem == 64'd0) begin
               fail = 1'b1;
            end else begin
               st = cbis_pkg::STATUS_BUSY;
            end
         end
         if (fail) begin
            trk_error = 1'b1;
            trk_active = 1'b0;
            trk_phase = cbis_pkg::PH_INIT;
            trk_arg_left = 4'd0;
            trk_payload = 32'd0;
            st = cbis_pkg::STATUS_ERROR;
         end
      end
      r.status = st;
      r.head_major = trk_last_major;
      r.head_argument = trk_last_arg;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 24);
   endfunction

   // add one byte at the tail of the encoded item
   function automatic void append_byte(input logic [7:0] v);
      enc_bytes.insert(enc_bytes.size(), v);
   endfunction

   // append a head, sometimes wider than it needs to be
   function automatic void push_head(input logic [2:0] mj, input logic [63:0] v);
      int lg;
      if (v < 64'(cbis_pkg::AI_DIRECT_LIMIT) && $urandom_range(0, 3) != 0) lg = -1;
      else if (v < 64'h100) lg = 0;
      else if (v < 64'h1_0000) lg = 1;
      else if (v < 64'h1_0000_0000) lg = 2;
      else lg = 3;
      if (lg < 3 && $urandom_range(0, 4) == 0) lg++;
      if (lg < 0) begin
         append_byte({mj, v[4:0]});
      end else begin
         append_byte({mj, cbis_pkg::AI_DIRECT_LIMIT + 5'(lg)});
         for (int i = (1 << lg) - 1; i >= 0; i--) append_byte(v[8*i +: 8]);
      end
   endfunction

   // build one well-formed item; containers stop after a few heads
   function automatic void build_item();
      int           owed;
      int           heads;
      int           n;
      gen_kind_type kind;
      enc_bytes.delete();
      owed = 1;
      heads = 0;
      while (owed > 0) begin
         owed--;
         heads++;
         kind = gen_kind_type'($urandom_range(0, heads > 6 ? 2 : 4));
         case (kind)
            GEN_NUMBER: begin
               push_head($urandom_range(0, 1) ? MAJOR_NEGATIVE : MAJOR_UNSIGNED,
                         {$urandom, $urandom} >> $urandom_range(0, 63));
            end
            GEN_SIMPLE: begin
               case ($urandom_range(0, 2))
                  0: append_byte(cbis_pkg::SIMPLE_FALSE);
                  1: append_byte(cbis_pkg::SIMPLE_TRUE);
                  default: append_byte(cbis_pkg::SIMPLE_NULL);
               endcase
            end
            GEN_STRING: begin
               n = $urandom_range(0, 6);
               push_head($urandom_range(0, 1) ? cbis_pkg::MAJOR_TEXT : cbis_pkg::MAJOR_BYTES,
                         64'(n));
               repeat (n) append_byte(8'($urandom));
            end
            GEN_ARRAY: begin
               n = $urandom_range(0, 3);
               push_head(cbis_pkg::MAJOR_ARRAY, 64'(n));
               owed += n;
            end
            default: begin
               n = $urandom_range(0, 2);
               push_head(cbis_pkg::MAJOR_MAP, 64'(n));
               owed += 2 * n;
            end
         endcase
      end
   endfunction

   task automatic send_byte(input cbis_pkg::req_type it, input bit typed,
                            input cbis_pkg::rsp_type want);
      int gap;
      gap = steady_req ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      row_typed <= typed;
      row_rsp <= want;
      do @(posedge clock); while (!req_ready);
   endtask

   // predict on every accepted byte, check every accepted result
   always @(posedge clock) begin
      cbis_pkg::rsp_type pred;
      if (!reset && req_valid && req_ready) begin
         pred = skip_step(req_item);
         byte_result_q.insert(byte_result_q.size(), row_typed ? row_rsp : pred);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (byte_result_q.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("unexpected result: status %0d major %0d arg %h",
                        rsp_item.status, rsp_item.head_major, rsp_item.head_argument);
         end else begin
            pred = byte_result_q.pop_front();
            if (rsp_item.status === cbis_pkg::STATUS_DONE) done_seen++;
            if (rsp_item.status === cbis_pkg::STATUS_ERROR) error_seen++;
            if (rsp_item.status !== pred.status || rsp_item.head_major !== pred.head_major ||
                rsp_item.head_argument !== pred.head_argument) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("mismatch: expected status %0d major %0d arg %h, got %0d %0d %h",
                           pred.status, pred.head_major, pred.head_argument,
                           rsp_item.status, rsp_item.head_major, rsp_item.head_argument);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!steady_ready && $urandom_range(0, 4) == 0) stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("cbor_item_skip_checker verification failed");
            $finish;
         end
      end
   end

   initial begin
      int                pick;
      int                sz;
      int                send_len;
      logic [31:0]       buf_len;
      cbis_pkg::req_type it;
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      rsp_ready = 1'b0;
      row_typed = 1'b0;
      row_rsp = '0;
      steady_req = 1'b0;
      steady_ready = 1'b0;
      stall_left = 0;
      quiet_cycles = 0;
      fault_count = 0;
      done_seen = 0;
      error_seen = 0;
      directed_sent = 0;
      random_sent = 0;
      trk_active = 1'b0;
      trk_error = 1'b0;
      trk_phase = cbis_pkg::PH_INIT;
      trk_held_major = 3'd0;
      trk_arg_left = 4'd0;
      trk_acc = 64'd0;
      trk_payload = 32'd0;
      trk_owed = 34'd0;
      trk_last_major = 3'd0;
      trk_last_arg = 64'd0;

      dir_tab = '{
         // idle after reset, then the smallest items
         '{'{8'h00, 1'b0, 32'd5}, 1'b1, '{cbis_pkg::STATUS_IDLE, MAJOR_UNSIGNED, 64'd0}},
         '{'{8'h00, 1'b1, 32'd0}, 1'b1, '{cbis_pkg::STATUS_DONE, MAJOR_UNSIGNED, 64'd0}},
         // widest argument, all ones
         '{'{8'h1B, 1'b1, 32'd8}, 1'b0, '0},
         '{'{8'hFF, 1'b0, 32'd7}, 1'b0, '0},
         '{'{8'hFF, 1'b0, 32'd6}, 1'b0, '0},
         '{'{8'hFF, 1'b0, 32'd5}, 1'b0, '0},
         '{'{8'hFF, 1'b0, 32'd4}, 1'b0, '0},
         '{'{8'hFF, 1'b0, 32'd3}, 1'b0, '0},
         '{'{8'hFF, 1'b0, 32'd2}, 1'b0, '0},
         '{'{8'hFF, 1'b0, 32'd1}, 1'b0, '0},
         '{'{8'hFF, 1'b0, 32'd0}, 1'b1,
           '{cbis_pkg::STATUS_DONE, MAJOR_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF}},
         '{'{8'hF4, 1'b1, 32'd0}, 1'b1,
           '{cbis_pkg::STATUS_DONE, cbis_pkg::MAJOR_SIMPLE, 64'd20}},
         // tag, then the error holds without a start
         '{'{8'hC0, 1'b1, 32'd4}, 1'b1,
           '{cbis_pkg::STATUS_ERROR, cbis_pkg::MAJOR_SIMPLE, 64'd20}},
         '{'{8'h00, 1'b0, 32'd4}, 1'b1,
           '{cbis_pkg::STATUS_ERROR, cbis_pkg::MAJOR_SIMPLE, 64'd20}},
         '{'{8'hF7, 1'b1, 32'd4}, 1'b1,
           '{cbis_pkg::STATUS_ERROR, cbis_pkg::MAJOR_SIMPLE, 64'd20}},
         '{'{8'h1C, 1'b1, 32'd4}, 1'b1,
           '{cbis_pkg::STATUS_ERROR, cbis_pkg::MAJOR_SIMPLE, 64'd20}},
         '{'{8'h5F, 1'b1, 32'd4}, 1'b1,
           '{cbis_pkg::STATUS_ERROR, cbis_pkg::MAJOR_SIMPLE, 64'd20}},
         // argument cut short, then a string longer than the buffer
         '{'{8'h19, 1'b1, 32'd1}, 1'b1,
           '{cbis_pkg::STATUS_ERROR, cbis_pkg::MAJOR_SIMPLE, 64'd20}},
         '{'{8'h43, 1'b1, 32'd2}, 1'b1,
           '{cbis_pkg::STATUS_ERROR, cbis_pkg::MAJOR_BYTES, 64'd3}},
         // array abandoned by a restart into a map
         '{'{8'h82, 1'b1, 32'd9}, 1'b0, '0},
         '{'{8'hA1, 1'b1, 32'd5}, 1'b0, '0},
         '{'{8'h61, 1'b0, 32'd4}, 1'b0, '0},
         '{'{8'h41, 1'b0, 32'd3}, 1'b0, '0},
         '{'{8'h80, 1'b0, 32'd2}, 1'b0, '0},
         // buffer ends before the array does
         '{'{8'h82, 1'b1, 32'd5}, 1'b0, '0},
         '{'{8'h00, 1'b0, 32'd0}, 1'b1, '{cbis_pkg::STATUS_ERROR, MAJOR_UNSIGNED, 64'd0}}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[k]) begin
         send_byte(dir_tab[k].item, dir_tab[k].typed, dir_tab[k].want);
         directed_sent++;
      end

      while (random_sent < RANDOM_BYTES) begin
         steady_req = ($urandom_range(0, 3) == 0);
         steady_ready <= ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick >= 90) begin
            // noise: arbitrary bytes, starts and lengths
            repeat ($urandom_range(1, 4)) begin
               it.data_byte = 8'($urandom);
               it.start_req = 1'($urandom_range(0, 1));
               case ($urandom_range(0, 2))
                  0: it.bytes_remaining = 32'd0;
                  1: it.bytes_remaining = 32'($urandom_range(0, 15));
                  default: it.bytes_remaining = $urandom;
               endcase
               send_byte(it, 1'b0, '0);
               random_sent++;
            end
         end else begin
            build_item();
            sz = enc_bytes.size();
            send_len = sz;
            if (pick < 60) begin
               if ($urandom_range(0, 2) == 0) buf_len = $urandom_range(32'hFFFF_FFFF, sz);
               else buf_len = 32'(sz + $urandom_range(0, 2));
            end else if (pick < 72) begin
               // one byte replaced with anything
               enc_bytes[$urandom_range(0, sz - 1)] = 8'($urandom);
               buf_len = 32'(sz + $urandom_range(0, 3));
            end else if (pick < 82) begin
               // buffer no longer than the item, and only that much of it is sent
               buf_len = 32'($urandom_range(1, sz));
               send_len = int'(buf_len);
            end else begin
               // sent in part or in full, then left to the next start
               send_len = $urandom_range(1, sz);
               buf_len = 32'(sz + 10);
            end
            for (int i = 0; i < send_len; i++) begin
               it.data_byte = enc_bytes[i];
               it.start_req = (i == 0);
               it.bytes_remaining = buf_len - 32'(i) - 32'd1;
               send_byte(it, 1'b0, '0);
               random_sent++;
            end
            if (pick < 82 && $urandom_range(0, 3) == 0) begin
               it.data_byte = 8'($urandom);
               it.start_req = 1'b0;
               it.bytes_remaining = $urandom;
               send_byte(it, 1'b0, '0);
               random_sent++;
            end
         end
      end
      req_valid <= 1'b0;

      while (byte_result_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (byte_result_q.size() != 0) fault_count++;
      $display("run covered %0d directed and %0d random bytes", directed_sent, random_sent);
      $display("items finished cleanly: %0d, ended in error: %0d", done_seen, error_seen);
      if (fault_count == 0) begin
         $display("cbor_item_skip_checker verification clean");
      end else begin
         $display("%0d failures", fault_count);
         $display("cbor_item_skip_checker verification failed");
      end
      $finish;
   end

endmodule
